// ===== rtl/light_level_smoother_tamper_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the light level smoother
// Concurrent check wrappers on clk_i, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef LIGHT_LEVEL_SMOOTHER_TAMPER_ASSERT_SVH
`define LIGHT_LEVEL_SMOOTHER_TAMPER_ASSERT_SVH

// check that is off while rst_ni is low
`define LLST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also runs during reset
`define LLST_ASSERT_AR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/llst_pkg.sv =====
// ----------------------------------------------------------------------------
// llst_pkg
// Widths, reset values and the sample scaling function of the smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package llst_pkg;

  localparam int unsigned RAW_W          = 12;
  localparam int unsigned LEVEL_W        = 10;
  localparam int unsigned DEFAULT_WINDOW = 8;

  localparam logic [RAW_W-1:0]   ADC_FULL     = 12'd4095;
  localparam logic [LEVEL_W-1:0] THRESH_RESET = 10'd512;

  // (4095 - raw) * 1023 / 4095, truncated.
  // x * 1023 = (x << 10) - x; division by 4095 = 2^12 - 1 uses
  // floor(y / 4095) = (y + (y >> 12) + 1) >> 12, exact for y < 2^24.
  function automatic logic [LEVEL_W-1:0] scale_sample(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] inv;
    logic [21:0]      prod;
    logic [22:0]      acc;
    inv  = ADC_FULL - raw;
    prod = {inv, 10'b0} - {10'b0, inv};
    acc  = {1'b0, prod} + {13'b0, prod[21:12]} + 23'd1;
    return acc[21:12];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/llst_cell.sv =====
// ----------------------------------------------------------------------------
// llst_cell
// One window entry: holds a scaled sample and passes it on at each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module llst_cell
  import llst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic [LEVEL_W-1:0] d_i,
  output logic [LEVEL_W-1:0] q_o
);

  logic [LEVEL_W-1:0] sample_q, sample_d;

  assign sample_d = shift_i ? d_i : sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  assign q_o = sample_q;

endmodule

`default_nettype wire

// ===== rtl/llst_mean.sv =====
// ----------------------------------------------------------------------------
// llst_mean
// Window sum divided by WINDOW through a registered reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module llst_mean
  import llst_pkg::*;
#(
  parameter int unsigned WINDOW = DEFAULT_WINDOW,
  parameter int unsigned SUM_W  = LEVEL_W + $clog2(WINDOW)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [SUM_W-1:0]   sum_i,
  output logic [LEVEL_W-1:0] mean_o
);

  // floor(s / W) = (s * ceil(2^K / W)) >> K for s < 2^SUM_W, K = SUM_W + clog2(W)
  localparam int unsigned SHIFT  = SUM_W + $clog2(WINDOW);
  localparam int unsigned RCP_W  = SUM_W + 2;
  localparam int unsigned PROD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [PROD_W-1:0] prod_q, prod_d;

  assign prod_d = load_i ? (PROD_W'(sum_i) * PROD_W'(RECIP)) : prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else begin
      prod_q <= prod_d;
    end
  end

  assign mean_o = prod_q[SHIFT +: LEVEL_W];

endmodule

`default_nettype wire

// ===== rtl/light_level_smoother_tamper.sv =====
// ----------------------------------------------------------------------------
// light_level_smoother_tamper
// Moving average of inverted, scaled light samples with a tamper threshold.
// ----------------------------------------------------------------------------
//  port group   handshake                  payload
//  input        in_valid_i / in_ready_o    raw_sample_i
//  result       out_valid_o / out_ready_i  light_level_o, tamper_o,
//                                          tamper_rise_o, tamper_fall_o
//  config       cfg_valid_i / cfg_ready_o  cfg_tamper_threshold_i
//
//  One item per cycle sustained while the result side accepts; each item passes
//  through four register stages (scale, window shift with running sum,
//  reciprocal multiply, compare).
//  Each stage moves when the stage after it is empty or moving, so bubbles
//  fill while a result waits at the output register.
//  Reset clears the window cells, the sum, the tamper flag and all valids;
//  no clearing pass is needed. Config is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "light_level_smoother_tamper_assert.svh"

module light_level_smoother_tamper
  import llst_pkg::*;
#(
  parameter int unsigned WINDOW = DEFAULT_WINDOW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [RAW_W-1:0]   raw_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LEVEL_W-1:0] light_level_o,
  output logic               tamper_o,
  output logic               tamper_rise_o,
  output logic               tamper_fall_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LEVEL_W-1:0] cfg_tamper_threshold_i
);

  localparam int unsigned SUM_W = LEVEL_W + $clog2(WINDOW);

  // stage enables
  logic en1, en2, en3, en4;

  logic               s1_valid_q, s1_valid_d;
  logic [LEVEL_W-1:0] scaled_q, scaled_d;
  logic               s2_valid_q, s2_valid_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               s3_valid_q, s3_valid_d;
  logic               out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic               tamper_q, tamper_d;
  logic               rise_q, rise_d;
  logic               fall_q, fall_d;
  logic               tamper_flag_q, tamper_flag_d;
  logic [LEVEL_W-1:0] thresh_q, thresh_d;

  logic               shift;
  logic [LEVEL_W-1:0] cell_q [WINDOW];
  logic [LEVEL_W-1:0] mean;
  logic               now_tamper;

  assign en4 = !out_valid_q || out_ready_i;
  assign en3 = !s3_valid_q || en4;
  assign en2 = !s2_valid_q || en3;
  assign en1 = !s1_valid_q || en2;

  assign in_ready_o  = en1;
  assign cfg_ready_o = 1'b1;

  // stage 1: invert and scale
  assign s1_valid_d = en1 ? in_valid_i : s1_valid_q;
  assign scaled_d   = (en1 && in_valid_i) ? scale_sample(raw_sample_i) : scaled_q;

  // stage 2: window shift and running sum
  assign shift      = en2 && s1_valid_q;
  assign s2_valid_d = en2 ? s1_valid_q : s2_valid_q;
  assign sum_d      = shift ? (sum_q + SUM_W'(scaled_q) - SUM_W'(cell_q[WINDOW-1])) : sum_q;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    llst_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     ((k == 0) ? scaled_q : cell_q[(k == 0) ? 0 : k-1]),
      .q_o     (cell_q[k])
    );
  end

  // stage 3: mean
  assign s3_valid_d = en3 ? s2_valid_q : s3_valid_q;

  llst_mean #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_mean (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (en3 && s2_valid_q),
    .sum_i  (sum_q),
    .mean_o (mean)
  );

  // stage 4: threshold and edge flags
  assign now_tamper    = mean > thresh_q;
  assign out_valid_d   = en4 ? s3_valid_q : out_valid_q;
  assign level_d       = (en4 && s3_valid_q) ? mean : level_q;
  assign tamper_d      = (en4 && s3_valid_q) ? now_tamper : tamper_q;
  assign rise_d        = (en4 && s3_valid_q) ? (now_tamper && !tamper_flag_q) : rise_q;
  assign fall_d        = (en4 && s3_valid_q) ? (!now_tamper && tamper_flag_q) : fall_q;
  assign tamper_flag_d = (en4 && s3_valid_q) ? now_tamper : tamper_flag_q;

  assign thresh_d = cfg_valid_i ? cfg_tamper_threshold_i : thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      s3_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      sum_q         <= '0;
      tamper_flag_q <= 1'b0;
      thresh_q      <= THRESH_RESET;
    end else begin
      s1_valid_q    <= s1_valid_d;
      s2_valid_q    <= s2_valid_d;
      s3_valid_q    <= s3_valid_d;
      out_valid_q   <= out_valid_d;
      sum_q         <= sum_d;
      tamper_flag_q <= tamper_flag_d;
      thresh_q      <= thresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scaled_q <= scaled_d;
    level_q  <= level_d;
    tamper_q <= tamper_d;
    rise_q   <= rise_d;
    fall_q   <= fall_d;
  end

  assign out_valid_o   = out_valid_q;
  assign light_level_o = level_q;
  assign tamper_o      = tamper_q;
  assign tamper_rise_o = rise_q;
  assign tamper_fall_o = fall_q;

  `LLST_ASSERT(a_no_rise_and_fall, out_valid_o |-> !(tamper_rise_o && tamper_fall_o), "rise+fall")
  `LLST_ASSERT(a_tamper_lvl, out_valid_o |-> tamper_o == (light_level_o > thresh_q), "bad tamper")
  `LLST_ASSERT(a_flag_sync, out_valid_o |-> tamper_flag_q == tamper_o, "flag out of step")
  `LLST_ASSERT(a_stall_at_out, !in_ready_o |-> out_valid_o && !out_ready_i, "needless stall")

endmodule

`default_nettype wire

// ===== tb/sv/tb_light_level_smoother_tamper.sv =====
// ----------------------------------------------------------------------------
// tb_light_level_smoother_tamper
// Sends raw light samples and threshold writes, with random idle bursts on the
// input and the result side. A local model of the averaging window predicts
// every result, and each result is checked field by field against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_light_level_smoother_tamper;
  import llst_pkg::*;

  localparam int unsigned WINDOW       = DEFAULT_WINDOW;
  localparam int          LEVEL_FULL   = 1023;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned RANDOM_ITEMS = 1330;
  localparam int unsigned TAIL_ITEMS   = 150;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               tamper;
    logic               rise;
    logic               fall;
  } light_result_t;

  logic               clk_i                  = 1'b0;
  logic               rst_ni                 = 1'b0;
  logic               in_valid_i             = 1'b0;
  logic               in_ready_o;
  logic [RAW_W-1:0]   raw_sample_i           = '0;
  logic               out_valid_o;
  logic               out_ready_i            = 1'b1;
  logic [LEVEL_W-1:0] light_level_o;
  logic               tamper_o;
  logic               tamper_rise_o;
  logic               tamper_fall_o;
  logic               cfg_valid_i            = 1'b0;
  logic               cfg_ready_o;
  logic [LEVEL_W-1:0] cfg_tamper_threshold_i = '0;

  // model of the window
  logic [LEVEL_W-1:0] window_cells [WINDOW];
  int unsigned        cell_pos;
  logic               tamper_prev;
  logic [LEVEL_W-1:0] threshold_now;

  light_result_t awaited_levels [$];

  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned rx_stall_left;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned rises_seen;
  int unsigned falls_seen;
  int unsigned thresholds_written;

  light_level_smoother_tamper i_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .raw_sample_i           (raw_sample_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .light_level_o          (light_level_o),
    .tamper_o               (tamper_o),
    .tamper_rise_o          (tamper_rise_o),
    .tamper_fall_o          (tamper_fall_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_tamper_threshold_i (cfg_tamper_threshold_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               awaited_levels.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // inverts and scales one sample into the window, returns the new average
  function automatic light_result_t smooth_sample(input logic [RAW_W-1:0] raw);
    int unsigned   inverted;
    int unsigned   level_sum;
    light_result_t res;
    inverted = int'(ADC_FULL) - int'(raw);
    window_cells[cell_pos] = LEVEL_W'((inverted * LEVEL_FULL) / int'(ADC_FULL));
    cell_pos = (cell_pos + 1) % WINDOW;
    level_sum = 0;
    foreach (window_cells[k]) level_sum += window_cells[k];
    res.level  = LEVEL_W'(level_sum / WINDOW);
    res.tamper = (res.level > threshold_now);
    res.rise   = res.tamper && !tamper_prev;
    res.fall   = !res.tamper && tamper_prev;
    tamper_prev = res.tamper;
    return res;
  endfunction

  // result side: random stall bursts
  always @(negedge clk_i) begin
    if (rx_stall_left > 0) begin
      out_ready_i = 1'b0;
      rx_stall_left--;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      out_ready_i = 1'b0;
      rx_stall_left = $urandom_range(0, 13);
    end else begin
      out_ready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    light_result_t seen;
    light_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = '{light_level_o, tamper_o, tamper_rise_o, tamper_fall_o};
      results_seen++;
      if (awaited_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: level=%0d tamper=%b rise=%b fall=%b",
                   seen.level, seen.tamper, seen.rise, seen.fall);
      end else begin
        want = awaited_levels.pop_front();
        if (want.rise) rises_seen++;
        if (want.fall) falls_seen++;
        if (seen.level !== want.level || seen.tamper !== want.tamper ||
            seen.rise !== want.rise || seen.fall !== want.fall) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d exp/act: level %0d/%0d tamper %b/%b rise %b/%b fall %b/%b",
                     results_seen, want.level, seen.level, want.tamper, seen.tamper,
                     want.rise, seen.rise, want.fall, seen.fall);
        end
      end
    end
  end

  task automatic hold_input(input int unsigned cycles);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic feed_sample(input logic [RAW_W-1:0] raw);
    if (tx_idle_on && $urandom_range(0, 5) == 0) hold_input($urandom_range(1, 14));
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    raw_sample_i = raw;
    do @(posedge clk_i); while (!in_ready_o);
    awaited_levels.push_back(smooth_sample(raw));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited_levels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // only called with the pipeline empty
  task automatic write_threshold(input logic [LEVEL_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i            = 1'b1;
    cfg_tamper_threshold_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    threshold_now = value;
    thresholds_written++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // mix of steady light runs near a level, noise and full bright/dark swings
  task automatic feed_pattern(input int unsigned count);
    int unsigned      left;
    int unsigned      run;
    int               target;
    int               raw_val;
    logic [RAW_W-1:0] swing;
    left = count;
    while (left > 0) begin
      run = $urandom_range(1, 16);
      if (run > left) run = left;
      if ($urandom_range(0, 1) != 0) target = int'($urandom_range(0, LEVEL_FULL));
      else target = int'(threshold_now) + int'($urandom_range(0, 6)) - 3;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          repeat (run) begin
            raw_val = int'(ADC_FULL) - (target * int'(ADC_FULL)) / LEVEL_FULL
                      + int'($urandom_range(0, 6)) - 3;
            if (raw_val < 0) raw_val = 0;
            if (raw_val > int'(ADC_FULL)) raw_val = int'(ADC_FULL);
            feed_sample(RAW_W'(raw_val));
          end
        end
        6, 7: begin
          repeat (run) feed_sample(RAW_W'($urandom));
        end
        default: begin
          swing = ($urandom_range(0, 1) != 0) ? RAW_W'(0) : ADC_FULL;
          repeat (run) feed_sample(swing);
        end
      endcase
      left -= run;
    end
  endtask

  // window starts at zero, so the first bright samples climb in steps of 1/8
  task automatic test_startup_ramp();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (WINDOW) feed_sample(RAW_W'(0));
    repeat (WINDOW) feed_sample(ADC_FULL);
    feed_sample(RAW_W'(1));
    feed_sample(ADC_FULL - 1);
    feed_sample(12'h800);
    feed_sample(12'hAAA);
    feed_sample(12'h555);
    wait_drained();
  endtask

  // max threshold can never be exceeded; zero trips on any nonzero level
  task automatic test_threshold_extremes();
    write_threshold('1);
    feed_sample(RAW_W'(0));
    feed_sample(RAW_W'(0));
    wait_drained();
    write_threshold('0);
    feed_sample(ADC_FULL);
    feed_sample(ADC_FULL);
    feed_sample(RAW_W'(0));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      case ($urandom_range(0, 5))
        0:       write_threshold('0);
        1:       write_threshold('1);
        default: write_threshold(LEVEL_W'($urandom));
      endcase
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      feed_pattern($urandom_range(60, 160));
      // sender holds off until every pending result is back
      wait_drained();
    end
  endtask

  task automatic test_steady_tail();
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    rx_stall_left = 0;
    write_threshold(THRESH_RESET);
    feed_pattern(TAIL_ITEMS);
    wait_drained();
  endtask

  initial begin
    foreach (window_cells[k]) window_cells[k] = '0;
    cell_pos      = 0;
    tamper_prev   = 1'b0;
    threshold_now = THRESH_RESET;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_startup_ramp();
    test_threshold_extremes();
    test_random_traffic();
    test_steady_tail();

    $display("Sent %0d samples and checked %0d results over %0d threshold settings.",
             items_sent, results_seen, thresholds_written);
    $display("Tamper was raised %0d times and cleared %0d times; %0d mismatches.",
             rises_seen, falls_seen, mismatches);
    if (mismatches == 0 && awaited_levels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/llst_pkg.sv
rtl/llst_cell.sv
rtl/llst_mean.sv
rtl/light_level_smoother_tamper.sv
tb/sv/tb_light_level_smoother_tamper.sv
